/* rtl/core/dwr_pkg.sv */
// ----------------------------------------------------------------------------
// dwr_pkg: shared types and constants for the deck draw core
// Deck size, derived widths, initial deck pattern, FSM and control types.
// ----------------------------------------------------------------------------
package dwr_pkg;

	localparam int DECK_SIZE = 64;
	localparam int ADDR_W    = (DECK_SIZE > 2) ? $clog2(DECK_SIZE) : 1;
	localparam int CNT_W     = $clog2(DECK_SIZE + 1);
	localparam int CARD_W    = 6;
	localparam int RAND_W    = 15;
	localparam int PAT_IDX_W = 6;
	localparam int STEP_W    = $clog2(RAND_W);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DIV    = 5'b00010,
		S_RDPOS  = 5'b00100,
		S_RDLAST = 5'b01000,
		S_SWAP   = 5'b10000
	} state_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic div_step;
		logic rd_pos;
		logic rd_last;
		logic swap;
		logic emit_exh;
	} cmd_t;

	typedef struct packed {
		logic exhausted;
		logic div_last;
	} sts_t;

	// Fixed deck order: evens 2..32, odds 1..31, evens, evens (period 64).
	function automatic logic [CARD_W-1:0] deck_init(input logic [ADDR_W-1:0] addr);
		logic [PAT_IDX_W-1:0] idx;
		logic [CARD_W-1:0]    k;
		idx = PAT_IDX_W'(addr);
		k   = CARD_W'(idx[3:0]);
		if (idx[5:4] == 2'b01)
			return CARD_W'({k[CARD_W-2:0], 1'b1});
		else
			return CARD_W'({k[CARD_W-2:0], 1'b0}) + CARD_W'(2);
	endfunction

endpackage

/* rtl/core/dwr_ram.sv */
// ----------------------------------------------------------------------------
// dwr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dwr_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/dwr_ctrl.sv */
// ----------------------------------------------------------------------------
// dwr_ctrl: draw sequencer
// Steps through division, two deck reads and the swap write for each item; a
// mode-0 draw on an exhausted deck only emits the exhausted result.
module dwr_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic         mode,
	input  dwr_pkg::sts_t sts,
	output dwr_pkg::cmd_t cmd,
	output logic         busy
);

	dwr_pkg::state_t state_q, state_d;
	logic            accept;

	assign accept = start && (state_q == dwr_pkg::S_IDLE);
	assign busy   = (state_q != dwr_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			dwr_pkg::S_IDLE: begin
				if (accept) begin
					cmd.load  = 1'b1;
					cmd.clear = mode;
					if (!mode && sts.exhausted)
						cmd.emit_exh = 1'b1;
					else
						state_d = dwr_pkg::S_DIV;
				end
			end
			dwr_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_d = dwr_pkg::S_RDPOS;
			end
			dwr_pkg::S_RDPOS: begin
				cmd.rd_pos = 1'b1;
				state_d    = dwr_pkg::S_RDLAST;
			end
			dwr_pkg::S_RDLAST: begin
				cmd.rd_last = 1'b1;
				state_d     = dwr_pkg::S_SWAP;
			end
			dwr_pkg::S_SWAP: begin
				cmd.swap = 1'b1;
				state_d  = dwr_pkg::S_IDLE;
			end
			default: state_d = dwr_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= dwr_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

/* rtl/core/dwr_dp.sv */
// ----------------------------------------------------------------------------
// dwr_dp: draw datapath
// Bit-serial modulo, deck RAM with per-entry valid bits, draw count, outputs.
// ----------------------------------------------------------------------------
module dwr_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dwr_pkg::cmd_t               cmd,
	input  logic [dwr_pkg::RAND_W-1:0]  random_value,
	output dwr_pkg::sts_t               sts,
	output logic [dwr_pkg::CARD_W-1:0]  card,
	output logic                        exhausted,
	output logic                        done
);

	logic [dwr_pkg::CNT_W-1:0]     count_q;
	logic [dwr_pkg::DECK_SIZE-1:0] valid_q;
	logic [dwr_pkg::RAND_W-1:0]    quo_q;
	logic [dwr_pkg::CNT_W-1:0]     rem_q;
	logic [dwr_pkg::STEP_W-1:0]    step_q;
	logic [dwr_pkg::CARD_W-1:0]    card_q;
	logic                          exh_q;
	logic                          done_q;

	logic [dwr_pkg::CNT_W-1:0]  left;
	logic [dwr_pkg::CNT_W:0]    trial;
	logic [dwr_pkg::CNT_W-1:0]  rem_d;
	logic [dwr_pkg::ADDR_W-1:0] pos;
	logic [dwr_pkg::ADDR_W-1:0] last;
	logic [dwr_pkg::ADDR_W-1:0] raddr;
	logic [dwr_pkg::CARD_W-1:0] rdata;
	logic [dwr_pkg::CARD_W-1:0] pos_card;
	logic [dwr_pkg::CARD_W-1:0] last_card;

	assign left  = dwr_pkg::CNT_W'(dwr_pkg::DECK_SIZE) - count_q;
	assign last  = dwr_pkg::ADDR_W'(left - dwr_pkg::CNT_W'(1));
	assign pos   = rem_q[dwr_pkg::ADDR_W-1:0];
	assign raddr = cmd.rd_pos ? pos : last;

	// restoring modulo step: one dividend bit per cycle
	always_comb begin
		trial = {rem_q, quo_q[dwr_pkg::RAND_W-1]};
		if (trial >= {1'b0, left})
			rem_d = dwr_pkg::CNT_W'(trial - {1'b0, left});
		else
			rem_d = dwr_pkg::CNT_W'(trial);
	end

	assign pos_card  = valid_q[pos]  ? rdata : dwr_pkg::deck_init(pos);
	assign last_card = valid_q[last] ? rdata : dwr_pkg::deck_init(last);

	dwr_ram #(
		.WIDTH(dwr_pkg::CARD_W),
		.DEPTH(dwr_pkg::DECK_SIZE)
	) u_deck (
		.clk  (clk),
		.we   (cmd.swap),
		.waddr(pos),
		.wdata(last_card),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			valid_q <= '0;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.swap | cmd.emit_exh;
			if (cmd.clear) begin
				count_q <= '0;
				valid_q <= '0;
			end else if (cmd.swap) begin
				count_q      <= count_q + dwr_pkg::CNT_W'(1);
				valid_q[pos] <= 1'b1;
			end
			if (cmd.load)
				step_q <= '0;
			else if (cmd.div_step)
				step_q <= step_q + dwr_pkg::STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quo_q <= random_value;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[dwr_pkg::RAND_W-2:0], 1'b0};
			rem_q <= rem_d;
		end
		if (cmd.emit_exh) begin
			card_q <= '0;
			exh_q  <= 1'b1;
		end else if (cmd.rd_last) begin
			card_q <= pos_card;
			exh_q  <= 1'b0;
		end
	end

	assign sts.exhausted = (count_q == dwr_pkg::CNT_W'(dwr_pkg::DECK_SIZE));
	assign sts.div_last  = (step_q == dwr_pkg::STEP_W'(dwr_pkg::RAND_W - 1));

	assign card      = card_q;
	assign exhausted = exh_q;
	assign done      = done_q;

endmodule

/* rtl/core/deck_draw_without_replacement_core.sv */
// ----------------------------------------------------------------------------
// deck_draw_without_replacement_core: random draw without replacement
// Deals deck entries at random, one per transfer, restoring the deck on mode 1.
// ----------------------------------------------------------------------------
// A draw runs the bit-serial modulo and then the RAM read, read, write
// sequence; busy is high throughout, and the next draw is accepted only
// once busy has fallen and the result is strobed.
// A mode-0 draw on an exhausted deck shows done the next cycle and leaves busy low.
// Results are strobed for one cycle and cannot be stalled.
// Reset (arst_n low) restores the full deck order and clears the drawn count.
module deck_draw_without_replacement_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        mode,
	input  logic [dwr_pkg::RAND_W-1:0]  random_value,
	output logic                        done,
	output logic [dwr_pkg::CARD_W-1:0]  card,
	output logic                        exhausted
);

	dwr_pkg::cmd_t cmd;
	dwr_pkg::sts_t sts;

	dwr_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.mode  (mode),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	dwr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.random_value(random_value),
		.sts         (sts),
		.card        (card),
		.exhausted   (exhausted),
		.done        (done)
	);

`ifndef SYNTH
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted transfer neither started nor completed");

	a_busy_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("draw finished without a result strobe");

	a_exh_card_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && exhausted |-> card == '0)
		else $error("exhausted result with nonzero card");
`endif

endmodule

/* test/tb_deck_draw_without_replacement_core.sv */
// ----------------------------------------------------------------------------
// tb_deck_draw_without_replacement_core: self-checking bench for the deck core
// Drives draw commands over start/busy and predicts every strobed result with
// a local deck model. It covers directed extremes, a full exhaustion of the
// deck, a pause that lets results drain, random runs of restore-then-draw
// sequences with or without random idle gaps, and short bursts of random modes.
// ----------------------------------------------------------------------------
module tb_deck_draw_without_replacement_core;

	localparam int CLK_HALF    = 4;
	localparam int RESET_CYC   = 12;
	localparam int TAIL_CYC    = 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 600;

	localparam logic MODE_DRAW    = 1'b0;
	localparam logic MODE_RESTORE = 1'b1;

	typedef struct {
		logic [dwr_pkg::CARD_W-1:0] card;
		logic                       exhausted;
	} draw_result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic                       mode;
	logic [dwr_pkg::RAND_W-1:0] random_value;
	logic                       done;
	logic [dwr_pkg::CARD_W-1:0] card;
	logic                       exhausted;

	logic [dwr_pkg::CARD_W-1:0] deck_model [dwr_pkg::DECK_SIZE];
	int unsigned                dealt_count;
	draw_result_t               pending_q [$];
	int                         error_count;
	int                         sent_count;

	deck_draw_without_replacement_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.random_value(random_value),
		.done        (done),
		.card        (card),
		.exhausted   (exhausted)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb_deck_draw_without_replacement_core: errors");
		$finish;
	end

	// Fixed order: evens 2..32, odds 1..31, then evens twice more.
	function automatic void restore_model();
		int i;
		for (i = 0; i < dwr_pkg::DECK_SIZE; i++) begin
			if ((i % 64) / 16 == 1)
				deck_model[i] = dwr_pkg::CARD_W'(2 * (i % 16) + 1);
			else
				deck_model[i] = dwr_pkg::CARD_W'(2 * (i % 16) + 2);
		end
		dealt_count = 0;
	endfunction

	function automatic draw_result_t deal_card(input logic m,
		input logic [dwr_pkg::RAND_W-1:0] r);
		draw_result_t res;
		int unsigned left;
		int unsigned pos;
		if (m == MODE_RESTORE)
			restore_model();
		if (dealt_count >= dwr_pkg::DECK_SIZE) begin
			res.card = '0;
			res.exhausted = 1'b1;
		end else begin
			left = dwr_pkg::DECK_SIZE - dealt_count;
			pos = int'(r) % left;
			res.card = deck_model[pos];
			res.exhausted = 1'b0;
			deck_model[pos] = deck_model[left - 1];
			dealt_count++;
		end
		return res;
	endfunction

	always @(posedge clk) begin
		draw_result_t exp_res;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result card=%0d exhausted=%0b",
					$time, card, exhausted);
				error_count++;
			end else begin
				exp_res = pending_q.pop_front();
				if (card !== exp_res.card) begin
					$display("%0t: card mismatch expected=%0d actual=%0d",
						$time, exp_res.card, card);
					error_count++;
				end
				if (exhausted !== exp_res.exhausted) begin
					$display("%0t: exhausted mismatch expected=%0b actual=%0b",
						$time, exp_res.exhausted, exhausted);
					error_count++;
				end
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_draw(input logic m, input logic [dwr_pkg::RAND_W-1:0] r);
		start <= 1'b1;
		mode <= m;
		random_value <= r;
		do @(posedge clk); while (busy);
		pending_q.push_back(deal_card(m, r));
		sent_count++;
		@(negedge clk);
	endtask

	task automatic idle_for(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return 0;
		else if (sel < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	function automatic logic [dwr_pkg::RAND_W-1:0] pick_rand();
		case ($urandom_range(0, 4))
			0: return dwr_pkg::RAND_W'($urandom_range(0, 127));
			1: return $urandom_range(0, 1) ? {dwr_pkg::RAND_W{1'b1}} : '0;
			2: return dwr_pkg::RAND_W'($urandom_range(32640, 32767));
			default: return dwr_pkg::RAND_W'($urandom_range(0, 32767));
		endcase
	endfunction

	task automatic test_extremes();
		send_draw(MODE_DRAW, 15'd31);
		send_draw(MODE_DRAW, 15'd0);
		send_draw(MODE_DRAW, 15'h7fff);
		send_draw(MODE_DRAW, 15'd1);
		send_draw(MODE_RESTORE, 15'h7fff);
		send_draw(MODE_DRAW, 15'd63);
		idle_for(5);
		send_draw(MODE_RESTORE, 15'd16);
		send_draw(MODE_DRAW, 15'h5555);
		send_draw(MODE_DRAW, 15'h2aaa);
		send_draw(MODE_RESTORE, 15'd0);
		send_draw(MODE_DRAW, 15'd64);
		idle_for(1);
	endtask

	task automatic test_exhaust();
		int i;
		send_draw(MODE_RESTORE, pick_rand());
		for (i = 1; i < dwr_pkg::DECK_SIZE; i++)
			send_draw(MODE_DRAW, pick_rand());
		// exhausted draws back to back, busy stays low
		send_draw(MODE_DRAW, 15'd0);
		send_draw(MODE_DRAW, 15'h7fff);
		send_draw(MODE_DRAW, pick_rand());
		idle_for(3);
		send_draw(MODE_DRAW, pick_rand());
		send_draw(MODE_RESTORE, 15'h7fff);
		send_draw(MODE_DRAW, pick_rand());
		idle_for(1);
	endtask

	task automatic test_drain_pause();
		int i;
		for (i = 0; i < 4; i++)
			send_draw(MODE_DRAW, pick_rand());
		start <= 1'b0;
		while (pending_q.size() != 0) @(negedge clk);
		send_draw(MODE_RESTORE, pick_rand());
		send_draw(MODE_DRAW, pick_rand());
		idle_for(1);
	endtask

	task automatic test_random_runs();
		int run_len;
		int i;
		logic no_gaps;
		while (sent_count < RANDOM_ITEMS) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0) begin
				// noise: a short burst of random modes
				run_len = $urandom_range(1, 6);
				for (i = 0; i < run_len; i++) begin
					send_draw(logic'($urandom_range(0, 1)), pick_rand());
					if (!no_gaps)
						idle_for(pick_gap());
				end
			end else begin
				run_len = $urandom_range(0, 3) == 0 ? $urandom_range(60, 70)
					: $urandom_range(1, 30);
				send_draw(MODE_RESTORE, pick_rand());
				for (i = 0; i < run_len; i++) begin
					if (!no_gaps)
						idle_for(pick_gap());
					send_draw(MODE_DRAW, pick_rand());
				end
				idle_for(pick_gap());
			end
		end
	endtask

	initial begin
		error_count = 0;
		sent_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_DRAW;
		random_value = '0;
		restore_model();
		repeat (RESET_CYC) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_extremes();
		test_exhaust();
		test_drain_pause();
		test_random_runs();

		start <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);
		if (error_count == 0 && pending_q.size() == 0)
			$display("tb_deck_draw_without_replacement_core: clean");
		else
			$display("tb_deck_draw_without_replacement_core: errors");
		$finish;
	end

endmodule
